/* hdl/kmp_stream_matcher_assert.svh */
// Assertion macros for the KMP stream matcher RTL.
// Used by files that check their own sequencing; no other dependencies.
`ifndef KMP_STREAM_MATCHER_ASSERT_SVH
`define KMP_STREAM_MATCHER_ASSERT_SVH

// Same-cycle implication, clocked on the rising edge, off during reset.
`define KMP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kmp_stream_matcher: assertion failed");

// Next-cycle implication, clocked on the rising edge, off during reset.
`define KMP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kmp_stream_matcher: assertion failed");

`endif

/* hdl/kmp_pkg.sv */
// Shared types and constants for the KMP stream matcher.
// No dependencies; used by the interfaces and every module.
`timescale 1ns / 1ps

package kmp_pkg;

    localparam int MAX_PATTERN = 64;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int ADDR_W      = $clog2(MAX_PATTERN);
    localparam int SYM_W       = 8;
    localparam int POS_W       = 32;

    // Request operation codes
    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_TEXT   = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_WALK
    } state_t;

    // Write requests to the pattern store and the failure table
    typedef struct packed {
        logic              store_we;
        logic [ADDR_W-1:0] store_addr;
        logic [SYM_W-1:0]  store_data;
        logic              fail_we;
        logic [LEN_W-1:0]  fail_addr;
        logic [LEN_W-1:0]  fail_data;
    } tbl_wr_t;

    // Outcome of one failure-link step
    typedef struct packed {
        logic             done;
        logic [LEN_W-1:0] len;
    } step_t;

endpackage

/* hdl/kmp_if.sv */
// Valid/ready channel interfaces for requests and results.
// Depends on kmp_pkg for field widths.
`timescale 1ns / 1ps

interface kmp_req_if;
    import kmp_pkg::*;

    logic             valid;
    logic             ready;
    logic [1:0]       operation;
    logic [SYM_W-1:0] symbol;

    modport source (output valid, output operation, output symbol, input ready);
    modport sink   (input valid, input operation, input symbol, output ready);
endinterface

interface kmp_res_if;
    import kmp_pkg::*;

    logic             valid;
    logic             ready;
    logic             match_found;
    logic [POS_W-1:0] match_end_position;
    logic             error;

    modport source (output valid, output match_found, output match_end_position,
                    output error, input ready);
    modport sink   (input valid, input match_found, input match_end_position,
                    input error, output ready);
endinterface

/* hdl/kmp_tables.sv */
// Pattern store and failure table memories, one write and one read address each.
// Depends on kmp_pkg; read data is registered.
`timescale 1ns / 1ps

module kmp_tables (
    input  logic                          clk,
    input  kmp_pkg::tbl_wr_t              wr,
    input  logic [kmp_pkg::LEN_W-1:0]     rd_addr,
    output logic [kmp_pkg::SYM_W-1:0]     store_q,
    output logic [kmp_pkg::LEN_W-1:0]     fail_q
);
    import kmp_pkg::*;

    logic [SYM_W-1:0] store_mem [MAX_PATTERN];
    logic [LEN_W-1:0] fail_mem  [MAX_PATTERN + 1];

    // Write pattern bytes
    always_ff @(posedge clk)
    begin
        if (wr.store_we)
        begin
            store_mem[wr.store_addr] <= wr.store_data;
        end
    end

    // Write border lengths
    always_ff @(posedge clk)
    begin
        if (wr.fail_we)
        begin
            fail_mem[wr.fail_addr] <= wr.fail_data;
        end
    end

    // Read both tables at the walk address
    always_ff @(posedge clk)
    begin
        store_q <= store_mem[rd_addr[ADDR_W-1:0]];
        fail_q  <= fail_mem[rd_addr];
    end

endmodule

/* hdl/kmp_step_unit.sv */
// Shared failure-link step: compare one stored byte and pick the next length.
// Depends on kmp_pkg; purely combinational.
`timescale 1ns / 1ps

module kmp_step_unit (
    input  logic [kmp_pkg::LEN_W-1:0] len,
    input  logic [kmp_pkg::SYM_W-1:0] sym,
    input  logic [kmp_pkg::SYM_W-1:0] store_q,
    input  logic [kmp_pkg::LEN_W-1:0] fail_q,
    output kmp_pkg::step_t            step
);
    import kmp_pkg::*;

    logic hit;
    logic at_root;

    // Extend on a hit, stop at the root, otherwise follow the link
    always_comb
    begin
        hit     = (store_q == sym);
        at_root = (len == '0);
        step.done = hit || at_root;
        if (hit)
        begin
            step.len = len + LEN_W'(1);
        end
        else if (at_root)
        begin
            step.len = '0;
        end
        else
        begin
            step.len = fail_q;
        end
    end

endmodule

/* hdl/kmp_stream_matcher.sv */
// Knuth-Morris-Pratt stream matcher top level: sequencer, state and result register.
// Depends on kmp_pkg, kmp_if, kmp_tables, kmp_step_unit and the assertion macros.
`timescale 1ns / 1ps
`include "kmp_stream_matcher_assert.svh"

// Streaming KMP matcher. A request appends a pattern byte (extending the failure
// table online), feeds a text byte, or clears pattern and matcher; each request
// returns exactly one result through a result register, so a new request is taken
// as soon as the previous result is taken or in the same cycle. Clear, refused
// appends, the first pattern byte, unused codes and text with an empty pattern are
// answered from the idle state. A text byte walks failure links in ST_WALK; a later
// pattern byte first reads its border in ST_FETCH, then walks. The walk holds while
// the result register is full. Every link is one read of the single read port of
// the pattern/failure tables. Each link shortens the match and each byte lengthens
// it by at most one, so on average at most one link is followed per byte. Memories
// need no clearing after reset.
module kmp_stream_matcher (
    input  logic      clk,
    input  logic      rst_n,
    kmp_req_if.sink   item,
    kmp_res_if.source result
);
    import kmp_pkg::*;

    state_t            state_reg,   state_next;
    logic [LEN_W-1:0]  count_reg,   count_next;
    logic [LEN_W-1:0]  matched_reg, matched_next;
    logic [LEN_W-1:0]  border_reg,  border_next;
    logic [LEN_W-1:0]  len_reg,     len_next;
    logic [SYM_W-1:0]  sym_reg,     sym_next;
    logic              is_app_reg,  is_app_next;
    logic [POS_W-1:0]  pos_reg,     pos_next;

    logic              res_valid_reg, res_valid_next;
    logic              found_reg,     found_next;
    logic [POS_W-1:0]  end_pos_reg,   end_pos_next;
    logic              err_reg,       err_next;

    logic              res_free;
    logic              res_load;
    logic              accept;
    tbl_wr_t           wr;
    logic [LEN_W-1:0]  rd_addr;
    logic [SYM_W-1:0]  store_q;
    logic [LEN_W-1:0]  fail_q;
    step_t             step;

    kmp_tables u_tables (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .store_q (store_q),
        .fail_q  (fail_q)
    );

    kmp_step_unit u_step (
        .len     (len_reg),
        .sym     (sym_reg),
        .store_q (store_q),
        .fail_q  (fail_q),
        .step    (step)
    );

    // Handshake
    assign res_free     = !res_valid_reg || result.ready;
    assign item.ready   = (state_reg == ST_IDLE) && res_free;
    assign accept       = item.valid && item.ready;

    assign result.valid              = res_valid_reg;
    assign result.match_found        = found_reg;
    assign result.match_end_position = end_pos_reg;
    assign result.error              = err_reg;

    // Sequencer: next state, table access and result load
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        matched_next = matched_reg;
        border_next  = border_reg;
        len_next     = len_reg;
        sym_next     = sym_reg;
        is_app_next  = is_app_reg;
        pos_next     = pos_reg;
        rd_addr      = len_reg;
        wr           = '0;
        res_load     = 1'b0;
        found_next   = 1'b0;
        end_pos_next = '0;
        err_next     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    sym_next = item.symbol;
                    case (item.operation)
                        OP_APPEND:
                        begin
                            if (count_reg >= LEN_W'(MAX_PATTERN))
                            begin
                                res_load = 1'b1;
                                err_next = 1'b1;
                            end
                            else
                            begin
                                wr.store_we   = 1'b1;
                                wr.store_addr = count_reg[ADDR_W-1:0];
                                wr.store_data = item.symbol;
                                if (count_reg == '0)
                                begin
                                    wr.fail_we   = 1'b1;
                                    wr.fail_addr = LEN_W'(1);
                                    wr.fail_data = '0;
                                    count_next   = LEN_W'(1);
                                    border_next  = '0;
                                    res_load     = 1'b1;
                                end
                                else
                                begin
                                    rd_addr     = count_reg;
                                    is_app_next = 1'b1;
                                    state_next  = ST_FETCH;
                                end
                            end
                        end
                        OP_TEXT:
                        begin
                            pos_next = pos_reg + POS_W'(1);
                            if (count_reg == '0)
                            begin
                                res_load = 1'b1;
                            end
                            else
                            begin
                                len_next    = matched_reg;
                                rd_addr     = matched_reg;
                                is_app_next = 1'b0;
                                state_next  = ST_WALK;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next   = '0;
                            matched_next = '0;
                            pos_next     = '0;
                            res_load     = 1'b1;
                        end
                        default:
                        begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_FETCH:
            begin
                // Start the walk at the border of the current pattern
                len_next   = fail_q;
                rd_addr    = fail_q;
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (!step.done)
                begin
                    len_next = step.len;
                    rd_addr  = step.len;
                end
                else if (res_free)
                begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                    if (is_app_reg)
                    begin
                        wr.fail_we   = 1'b1;
                        wr.fail_addr = count_reg + LEN_W'(1);
                        wr.fail_data = step.len;
                        count_next   = count_reg + LEN_W'(1);
                        border_next  = step.len;
                    end
                    else if (step.len == count_reg)
                    begin
                        found_next   = 1'b1;
                        end_pos_next = pos_reg - POS_W'(1);
                        matched_next = border_reg;
                    end
                    else
                    begin
                        matched_next = step.len;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Hold the result until taken
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            matched_reg   <= '0;
            border_reg    <= '0;
            pos_reg       <= '0;
            is_app_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            matched_reg   <= matched_next;
            border_reg    <= border_next;
            pos_reg       <= pos_next;
            is_app_reg    <= is_app_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
        sym_reg <= sym_next;
        if (res_load)
        begin
            found_reg   <= found_next;
            end_pos_reg <= end_pos_next;
            err_reg     <= err_next;
        end
    end

    `KMP_ASSERT_NXT(a_accept_busy, clk, rst_n, accept, (state_reg != ST_IDLE) || res_valid_reg)
    `KMP_ASSERT_IMP(a_matched_lt_count, clk, rst_n, 1'b1,
                    (count_reg == '0) || (matched_reg < count_reg))
    `KMP_ASSERT_IMP(a_border_lt_count, clk, rst_n, 1'b1,
                    (count_reg == '0) || (border_reg < count_reg))
    `KMP_ASSERT_IMP(a_count_max, clk, rst_n, 1'b1, count_reg <= LEN_W'(MAX_PATTERN))
    `KMP_ASSERT_IMP(a_fetch_append, clk, rst_n, state_reg == ST_FETCH, is_app_reg)
    `KMP_ASSERT_IMP(a_found_no_err, clk, rst_n, res_valid_reg, !(found_reg && err_reg))

endmodule

/* verif/kmp_stream_matcher_tb.sv */
// Self-checking testbench for kmp_stream_matcher: directed and random request
// streams, a local KMP predictor and a checker on the result channel.
// Depends on kmp_pkg, kmp_if and the kmp_stream_matcher RTL.
`timescale 1ns / 1ps

module kmp_stream_matcher_tb;
    import kmp_pkg::*;

    // Operation code 3 has no meaning; the block must answer it with an empty result
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 2000;
    localparam int CYCLE_LIMIT  = 1500000;
    localparam int TAIL_CYCLES  = 100;
    localparam int PRINT_CAP    = 40;

    typedef struct {
        logic [1:0]       op;
        logic [SYM_W-1:0] sym;
        bit               drain;
    } req_item_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] pos;
        logic             err;
    } outcome_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Driven copies of the block inputs, known from time zero
    logic             req_valid = 1'b0;
    logic [1:0]       req_op    = OP_CLEAR;
    logic [SYM_W-1:0] req_sym   = '0;
    logic             res_ready = 1'b0;
    logic             req_taken = 1'b0;

    kmp_req_if req_ch ();
    kmp_res_if res_ch ();

    assign req_ch.valid     = req_valid;
    assign req_ch.operation = req_op;
    assign req_ch.symbol    = req_sym;
    assign res_ch.ready     = res_ready;

    kmp_stream_matcher dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (req_ch),
        .result (res_ch)
    );

    // Predictor state: pattern bytes, border lengths and match progress
    logic [SYM_W-1:0] pat_bytes  [0:MAX_PATTERN-1];
    logic [LEN_W-1:0] border_len [0:MAX_PATTERN];
    logic [LEN_W-1:0] pat_count = '0;
    logic [LEN_W-1:0] match_len = '0;
    logic [POS_W-1:0] text_pos  = '0;

    req_item_t pending_reqs [$];
    outcome_t  expected_outcomes [$];
    outcome_t  want;
    req_item_t next_req;

    int mismatches   = 0;
    int accepted     = 0;
    int results_seen = 0;
    int matches_seen = 0;
    int refusals     = 0;
    int counted      = 0;
    int cycles       = 0;
    int gap_left     = 0;
    int stall_left   = 0;

    initial begin
        forever #2 clk = ~clk;
    end

    initial begin
        for (int i = 0; i < MAX_PATTERN; i++)
            pat_bytes[ADDR_W'(i)] = '0;
        for (int i = 0; i <= MAX_PATTERN; i++)
            border_len[LEN_W'(i)] = '0;
    end

    // Walk failure links from len until c extends the prefix or len reaches zero
    function automatic logic [LEN_W-1:0] follow_links(logic [LEN_W-1:0] len,
                                                      logic [SYM_W-1:0] c);
        while (len > 0 && pat_bytes[len[ADDR_W-1:0]] != c)
            len = border_len[len];
        if (pat_bytes[len[ADDR_W-1:0]] == c)
            len = len + 1'b1;
        return len;
    endfunction

    // Update the predictor for one request and return its result
    function automatic outcome_t predict_outcome(logic [1:0] op, logic [SYM_W-1:0] sym);
        outcome_t o;
        logic [LEN_W-1:0] j;
        o = '0;
        j = '0;
        case (op)
            OP_APPEND:
            begin
                if (pat_count >= MAX_PATTERN)
                    o.err = 1'b1;
                else
                begin
                    pat_bytes[pat_count[ADDR_W-1:0]] = sym;
                    if (pat_count > 0)
                        j = follow_links(border_len[pat_count], sym);
                    border_len[pat_count + LEN_W'(1)] = j;
                    pat_count = pat_count + 1'b1;
                end
            end
            OP_TEXT:
            begin
                if (pat_count > 0)
                begin
                    j = follow_links(match_len, sym);
                    if (j == pat_count)
                    begin
                        o.found = 1'b1;
                        o.pos   = text_pos;
                        j       = border_len[pat_count];
                    end
                    match_len = j;
                end
                text_pos = text_pos + 1'b1;
            end
            OP_CLEAR:
            begin
                pat_count     = '0;
                match_len     = '0;
                text_pos      = '0;
                border_len[0] = '0;
            end
            default: ;
        endcase
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [POS_W-1:0] got, logic [POS_W-1:0] exp_val);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("MISMATCH t=%0t %s: got %0h, wanted %0h", $time, what, got, exp_val);
    endtask

    // Most gaps are short, a few long; calm stretches have none
    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 8);
        return $urandom_range(9, 20);
    endfunction

    task automatic add_req(logic [1:0] op, logic [SYM_W-1:0] sym, bit drain);
        req_item_t it;
        it.op    = op;
        it.sym   = sym;
        it.drain = drain;
        pending_reqs.push_back(it);
        if (op != OP_UNUSED)
            counted++;
    endtask

    // One load-then-stream sequence over a small alphabet, or a burst of noise
    task automatic add_sequence(bit full_store, bit drain);
        int plen;
        int tlen;
        int asz;
        int r;
        logic [SYM_W-1:0] alpha [0:2];
        logic [SYM_W-1:0] pat_seq [$];
        if (!full_store && $urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(5, 30))
                add_req(2'($urandom_range(0, 3)), 8'($urandom), drain);
            return;
        end
        if (full_store || $urandom_range(0, 4) != 0)
            add_req(OP_CLEAR, 8'($urandom), drain);
        asz = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 3);
        for (int i = 0; i < 3; i++)
            alpha[2'(i)] = 8'($urandom);
        r = $urandom_range(0, 99);
        if (full_store)
            plen = $urandom_range(MAX_PATTERN, MAX_PATTERN + 3);
        else if (r < 70)
            plen = $urandom_range(1, 4);
        else if (r < 90)
            plen = $urandom_range(5, 12);
        else if (r < 97)
            plen = $urandom_range(13, 40);
        else
            plen = $urandom_range(MAX_PATTERN - 4, MAX_PATTERN + 2);
        for (int i = 0; i < plen; i++)
        begin
            pat_seq.push_back(alpha[2'($urandom_range(0, asz - 1))]);
            add_req(OP_APPEND, pat_seq[i], 1'b0);
        end
        tlen = full_store ? 150 : $urandom_range(10, 50);
        for (int t = 0; t < tlen; t++)
        begin
            r = $urandom_range(0, 99);
            if (r < 12)
            begin
                // Plant a whole occurrence of the stored part
                for (int i = 0; i < plen && i < MAX_PATTERN; i++)
                    add_req(OP_TEXT, pat_seq[i], 1'b0);
            end
            else if (r < 16)
                add_req(OP_TEXT, 8'($urandom), 1'b0);
            else if (r < 18)
                add_req(OP_APPEND, alpha[2'($urandom_range(0, asz - 1))], 1'b0);
            else if (r < 20)
                add_req(OP_UNUSED, 8'($urandom), 1'b0);
            else
                add_req(OP_TEXT, alpha[2'($urandom_range(0, asz - 1))], 1'b0);
        end
    endtask

    // Request driver: hold until taken, then idle or advance to the next request
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!req_valid || req_taken)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0 &&
                         !(pending_reqs[0].drain && expected_outcomes.size() > 0))
                begin
                    next_req  = pending_reqs.pop_front();
                    req_op    <= next_req.op;
                    req_sym   <= next_req.sym;
                    req_valid <= 1'b1;
                    gap_left  = pick_gap(((cycles / 500) % 4) == 0);
                end
                else
                    req_valid <= 1'b0;
            end
            // Result side: stall at random, with calm stretches of steady ready
            if (stall_left > 0)
            begin
                stall_left--;
                res_ready <= 1'b0;
            end
            else
            begin
                res_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap(((cycles / 700) % 5) == 1);
            end
        end
    end

    // Monitor: check each result, then predict each accepted request
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                results_seen++;
                if (expected_outcomes.size() == 0)
                    report_mismatch("result with no request outstanding", 0, 0);
                else
                begin
                    want = expected_outcomes.pop_front();
                    if (res_ch.match_found !== want.found)
                        report_mismatch("match_found", POS_W'(res_ch.match_found),
                                        POS_W'(want.found));
                    if (res_ch.match_end_position !== want.pos)
                        report_mismatch("match_end_position", res_ch.match_end_position,
                                        want.pos);
                    if (res_ch.error !== want.err)
                        report_mismatch("error", POS_W'(res_ch.error), POS_W'(want.err));
                    if (want.found)
                        matches_seen++;
                    if (want.err)
                        refusals++;
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                accepted++;
                expected_outcomes.push_back(predict_outcome(req_ch.operation, req_ch.symbol));
            end
            req_taken <= req_ch.valid && req_ch.ready;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_outcomes.size());
            $display("kmp_stream_matcher verification failed");
            $finish;
        end
    end

    initial begin
        int rand_start;

        // Directed: empty pattern, unused code, byte extremes, overlap, append mid-match
        add_req(OP_TEXT,   8'h00, 1'b0);
        add_req(OP_UNUSED, 8'hFF, 1'b0);
        add_req(OP_APPEND, 8'hFF, 1'b0);
        add_req(OP_TEXT,   8'hFF, 1'b0);
        add_req(OP_TEXT,   8'h00, 1'b0);
        add_req(OP_TEXT,   8'hFF, 1'b0);
        add_req(OP_CLEAR,  8'hA5, 1'b1);
        add_req(OP_TEXT,   8'h5A, 1'b0);
        add_req(OP_APPEND, 8'h00, 1'b0);
        add_req(OP_APPEND, 8'h00, 1'b0);
        add_req(OP_TEXT,   8'h00, 1'b0);
        add_req(OP_TEXT,   8'h00, 1'b0);
        add_req(OP_TEXT,   8'h00, 1'b0);
        add_req(OP_APPEND, 8'h01, 1'b0);
        add_req(OP_TEXT,   8'h01, 1'b0);
        add_req(OP_TEXT,   8'h00, 1'b0);
        add_req(OP_TEXT,   8'h00, 1'b0);
        add_req(OP_TEXT,   8'h01, 1'b0);
        add_req(OP_UNUSED, 8'h00, 1'b0);
        add_req(OP_TEXT,   8'hFF, 1'b0);
        add_req(OP_CLEAR,  8'hFF, 1'b0);
        add_req(OP_APPEND, 8'h80, 1'b0);
        add_req(OP_TEXT,   8'h80, 1'b0);

        // Random: fill the store to capacity or beyond first, then mixed sequences
        rand_start = counted;
        add_sequence(1'b1, 1'b1);
        while (counted - rand_start < RANDOM_ITEMS)
            add_sequence(1'b0, $urandom_range(0, 7) == 0);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait for the last request, every result, then a tail for stray results
        while (pending_reqs.size() > 0 || req_valid)
            @(posedge clk);
        while (expected_outcomes.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run covered %0d requests and %0d results in %0d cycles",
                 accepted, results_seen, cycles);
        $display("occurrences found: %0d, full-store refusals: %0d, mismatches: %0d",
                 matches_seen, refusals, mismatches);
        if (mismatches == 0 && expected_outcomes.size() == 0)
            $display("kmp_stream_matcher verification clean");
        else
            $display("kmp_stream_matcher verification failed");
        $finish;
    end

endmodule

/* kmp_stream_matcher.f */
+incdir+hdl
hdl/kmp_pkg.sv
hdl/kmp_if.sv
hdl/kmp_tables.sv
hdl/kmp_step_unit.sv
hdl/kmp_stream_matcher.sv
verif/kmp_stream_matcher_tb.sv
